// ===== hdl/bpc_pkg.sv =====
// Shared types and constants of the button press classifier.
`default_nettype none

package bpc_pkg;

    localparam int unsigned TIME_W = 32;

    typedef logic [TIME_W-1:0] t_time;

    // Result event codes.
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ACTIVE_HIGH   = 2'd0,
        CFG_DEBOUNCE_US   = 2'd1,
        CFG_DOUBLE_GAP_US = 2'd2,
        CFG_LONG_MIN_US   = 2'd3
    } t_cfg_idx;

    localparam logic  RST_ACTIVE_HIGH   = 1'b1;
    localparam t_time RST_DEBOUNCE_US   = 32'd50000;
    localparam t_time RST_DOUBLE_GAP_US = 32'd250000;
    localparam t_time RST_LONG_MIN_US   = 32'd1000000;

    typedef struct packed {
        logic  active_high;
        t_time debounce_us;
        t_time double_gap_us;
        t_time long_min_us;
    } t_cfg;

    typedef struct packed {
        t_event event_code;
        logic   debounced_level;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/bpc_intf.sv =====
// Handshake channel interfaces of the button press classifier.
`default_nettype none

interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_us;
    logic        raw_level;

    modport source (output valid, output now_us, output raw_level, input ready);
    modport sink   (input valid, input now_us, input raw_level, output ready);
endinterface

interface bpc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;
    logic       debounced_level;

    modport source (output valid, output event_code, output debounced_level, input ready);
    modport sink   (input valid, input event_code, input debounced_level, output ready);
endinterface

interface bpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bpc_cfg_regs.sv =====
// Configuration registers of the button press classifier.
`default_nettype none

module bpc_cfg_regs
    import bpc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_wr,
    input  wire  [1:0]  i_index,
    input  wire  [31:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_high   <= RST_ACTIVE_HIGH;
            r_cfg.debounce_us   <= RST_DEBOUNCE_US;
            r_cfg.double_gap_us <= RST_DOUBLE_GAP_US;
            r_cfg.long_min_us   <= RST_LONG_MIN_US;
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_ACTIVE_HIGH:   r_cfg.active_high   <= i_data[0];
                CFG_DEBOUNCE_US:   r_cfg.debounce_us   <= i_data;
                CFG_DOUBLE_GAP_US: r_cfg.double_gap_us <= i_data;
                CFG_LONG_MIN_US:   r_cfg.long_min_us   <= i_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hdl/bpc_classifier.sv =====
// Debounce and press classification state, advanced once per sample.
`default_nettype none

module bpc_classifier
    import bpc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_step,
    input  wire [31:0] i_now_us,
    input  wire        i_raw_level,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    logic  r_stable_level, n_stable_level;
    t_time r_stable_since, n_stable_since;
    logic  r_is_down, n_is_down;
    t_time r_down_time, n_down_time;
    t_time r_up_time, n_up_time;
    logic  r_double_waiting, n_double_waiting;
    logic  r_long_waiting, n_long_waiting;

    logic   level;
    logic   deb_ok;
    logic   press_edge;
    logic   release_edge;
    logic   gap_over;
    logic   hold_over;
    t_event ev;

    always_comb begin
        level  = i_cfg.active_high ? i_raw_level : ~i_raw_level;
        deb_ok = (i_now_us - r_stable_since) > i_cfg.debounce_us;

        n_stable_level   = r_stable_level;
        n_stable_since   = r_stable_since;
        n_is_down        = r_is_down;
        n_down_time      = r_down_time;
        n_up_time        = r_up_time;
        n_double_waiting = r_double_waiting;
        n_long_waiting   = r_long_waiting;
        ev               = EV_NONE;

        if (deb_ok && (r_stable_level != level)) begin
            n_stable_level = level;
            n_stable_since = i_now_us;
        end

        press_edge   = n_stable_level & ~r_is_down;
        release_edge = ~n_stable_level & r_is_down;

        // An edge restamps its time to now, so its own timeout cannot fire.
        gap_over  = ((i_now_us - r_up_time) > i_cfg.double_gap_us) & ~release_edge;
        hold_over = ((i_now_us - r_down_time) > i_cfg.long_min_us) & ~press_edge;

        n_is_down = n_stable_level;
        if (press_edge) begin
            n_down_time = i_now_us;
        end
        if (release_edge) begin
            n_up_time = i_now_us;
            priority if (r_long_waiting) begin
                n_double_waiting = 1'b0;
            end else if (r_double_waiting) begin
                ev               = EV_DOUBLE;
                n_double_waiting = 1'b0;
            end else begin
                n_double_waiting = 1'b1;
            end
            n_long_waiting = 1'b0;
        end

        priority if (!n_is_down && n_double_waiting && gap_over) begin
            n_double_waiting = 1'b0;
            ev               = EV_SINGLE;
        end else if (n_is_down && !n_long_waiting && hold_over) begin
            ev               = EV_LONG;
            n_long_waiting   = 1'b1;
            n_double_waiting = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_level   <= 1'b0;
            r_stable_since   <= '0;
            r_is_down        <= 1'b0;
            r_down_time      <= '0;
            r_up_time        <= '0;
            r_double_waiting <= 1'b0;
            r_long_waiting   <= 1'b0;
        end else if (i_step) begin
            r_stable_level   <= n_stable_level;
            r_stable_since   <= n_stable_since;
            r_is_down        <= n_is_down;
            r_down_time      <= n_down_time;
            r_up_time        <= n_up_time;
            r_double_waiting <= n_double_waiting;
            r_long_waiting   <= n_long_waiting;
        end
    end

    assign o_result.event_code      = ev;
    assign o_result.debounced_level = n_stable_level;

endmodule

`default_nettype wire

// ===== hdl/button_press_classifier.sv =====
// Top level of the button press classifier: sample register, classifier, result register.
//
// Channel  Dir  Payload                        Accepted when
// i_in     in   now_us[31:0], raw_level        i_in.valid && i_in.ready
// o_out    out  event_code[1:0], debounced     o_out.valid && o_out.ready
// i_cfg    in   index[1:0], data[31:0]         i_cfg.valid && i_cfg.ready
//
// Each sample passes from acceptance through the sample register, then
// through the classifier into the result register. A new sample is accepted
// every cycle while the result is not stalled. A stalled result holds the
// result register, then the sample register, and then i_in.ready falls.
// Reset is synchronous; it clears valid flags and classifier state and sets
// configuration defaults, not data. Configuration writes are always accepted.
`default_nettype none

module button_press_classifier
    import bpc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    bpc_in_if.sink     i_in,
    bpc_out_if.source  o_out,
    bpc_cfg_if.sink    i_cfg
);

    t_cfg    cfg;
    t_result result;

    logic  r_in_valid;
    t_time r_now_us;
    logic  r_raw_level;
    logic  r_out_valid;
    t_result r_result;

    logic advance;
    logic take_in;

    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign take_in = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    bpc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid && i_cfg.ready),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    bpc_classifier u_classifier (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_now_us    (r_now_us),
        .i_raw_level (r_raw_level),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_now_us    <= i_in.now_us;
            r_raw_level <= i_in.raw_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.event_code      = r_result.event_code;
    assign o_out.debounced_level = r_result.debounced_level;

endmodule

`default_nettype wire
